[src/bmseq_pkg.sv]
// ============================================================================
// Buzzer melody sequencer package
// Shared types and constants for the controller, datapath and divider.
// ============================================================================
package bmseq_pkg;

    localparam int NOTES_PER_SONG = 256;
    localparam int SONG_SLOTS     = 3;
    localparam int STORE_DEPTH    = SONG_SLOTS * NOTES_PER_SONG;
    localparam int ADDR_W         = 10;
    localparam int POS_W          = 8;
    localparam int TONE_W         = 16;
    localparam int BEATS_W        = 8;
    localparam int TICKS_W        = 24;
    localparam int QUOT_W         = 20;
    localparam int DIV_CNT_W      = 5;

    localparam logic [TONE_W-1:0]    TONE_END      = 16'd0;
    localparam logic [TONE_W-1:0]    TONE_REST     = 16'd1000;
    localparam logic [QUOT_W-1:0]    TIMER_TICK_HZ = 20'd1000000;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS     = 5'd20;
    localparam logic [15:0]          BEAT_MS_RESET = 16'd500;
    localparam logic [POS_W-1:0]     LAST_POS      = 8'(NOTES_PER_SONG - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SOUND,
        PH_GAP,
        PH_REST
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SETTLE,
        ST_SELECT,
        ST_READ,
        ST_NOTE,
        ST_DIV,
        ST_FINISH,
        ST_COUNT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [4:0]  buttons;
        logic [1:0]  load_song;
        logic [7:0]  load_position;
        logic [15:0] load_tone;
        logic [7:0]  load_beats;
    } t_in_item;

    typedef struct packed {
        logic [15:0] timer_period;
        logic [15:0] timer_compare;
        logic        playing;
        logic [1:0]  current_song;
        logic [7:0]  note_position;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic write_note;
        logic enter_gap;
        logic go_idle;
        logic advance;
        logic select;
        logic read;
        logic rest_start;
        logic div_start;
        logic note_sound;
        logic count;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_phase phase;
        logic   ticks_zero;
        logic   last_pos;
        logic   op_load;
        logic   btn_hit;
        logic   tone_end;
        logic   tone_rest;
        logic   div_done;
        logic   out_free;
    } t_status;

endpackage

[src/bmseq_div.sv]
// ============================================================================
// Tone divider
// Restoring divider that forms the timer tick rate over the tone, one
// quotient bit per cycle.
// ============================================================================
module bmseq_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [bmseq_pkg::TONE_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [bmseq_pkg::QUOT_W-1:0]  o_quotient
);

    logic [bmseq_pkg::QUOT_W-1:0]    r_quot;
    logic [bmseq_pkg::TONE_W-1:0]    r_rem;
    logic [bmseq_pkg::TONE_W-1:0]    r_div;
    logic [bmseq_pkg::DIV_CNT_W-1:0] r_count;
    logic [bmseq_pkg::TONE_W:0]      rem_sh;
    logic                            fits;

    assign rem_sh = {r_rem, r_quot[bmseq_pkg::QUOT_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_start) begin
            r_count <= bmseq_pkg::DIV_STEPS;
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= bmseq_pkg::TIMER_TICK_HZ;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_count != '0) begin
            if (fits) begin
                r_rem <= bmseq_pkg::TONE_W'(rem_sh - {1'b0, r_div});
            end else begin
                r_rem <= rem_sh[bmseq_pkg::TONE_W-1:0];
            end
            r_quot <= {r_quot[bmseq_pkg::QUOT_W-2:0], fits};
        end
    end

    assign o_done     = (r_count == '0);
    assign o_quotient = r_quot;

endmodule

[src/bmseq_dp.sv]
// ============================================================================
// Sequencer datapath
// Note store, song and note registers, tick counter, PWM values, beat
// register and the output register.
// ============================================================================
module bmseq_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bmseq_pkg::t_in_item  i_in_data,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_out_ready,
    input  bmseq_pkg::t_cmd      i_cmd,
    output bmseq_pkg::t_status   o_status,
    output logic                 o_out_valid,
    output bmseq_pkg::t_out_item o_out_data
);

    logic [23:0]                      r_mem [0:bmseq_pkg::STORE_DEPTH-1];
    bmseq_pkg::t_in_item              r_item;
    logic [23:0]                      r_rd_data;
    logic [15:0]                      r_beat_ms;
    logic [1:0]                       r_song;
    logic [bmseq_pkg::POS_W-1:0]      r_pos;
    bmseq_pkg::t_phase                r_phase;
    logic [bmseq_pkg::TICKS_W-1:0]    r_ticks;
    logic [15:0]                      r_period;
    logic [15:0]                      r_compare;
    logic [bmseq_pkg::BEATS_W-1:0]    r_beats;
    logic                             r_out_valid;
    bmseq_pkg::t_out_item             r_out_data;

    logic [1:0]                       sel_song;
    logic [31:0]                      gap_prod;
    logic [15:0]                      gap_ticks;
    logic [bmseq_pkg::QUOT_W-1:0]     quotient;
    logic [bmseq_pkg::QUOT_W-1:0]     arr;
    logic                             div_done;
    logic [bmseq_pkg::ADDR_W-1:0]     wr_addr;
    logic [bmseq_pkg::ADDR_W-1:0]     rd_addr;

    bmseq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_rd_data[bmseq_pkg::TONE_W-1:0]),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign wr_addr   = {r_item.load_song, r_item.load_position};
    assign rd_addr   = {r_song - 2'd1, r_pos};
    assign gap_prod  = 32'(r_beat_ms) * 32'd52429;
    assign gap_ticks = 16'(gap_prod >> 18);
    assign arr       = quotient - 1'b1;

    always_comb begin
        if (r_item.buttons[0]) begin
            sel_song = 2'd1;
        end else if (r_item.buttons[1]) begin
            sel_song = 2'd2;
        end else begin
            sel_song = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_note && (r_item.load_song < 2'(bmseq_pkg::SONG_SLOTS))) begin
            r_mem[wr_addr] <= {r_item.load_beats, r_item.load_tone};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
        if (i_cmd.div_start) begin
            r_beats <= r_rd_data[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_ms <= bmseq_pkg::BEAT_MS_RESET;
        end else if (i_cfg_we) begin
            r_beat_ms <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_song    <= '0;
            r_pos     <= '0;
            r_phase   <= bmseq_pkg::PH_IDLE;
            r_ticks   <= '0;
            r_period  <= '0;
            r_compare <= '0;
        end else begin
            if (i_cmd.go_idle) begin
                r_phase   <= bmseq_pkg::PH_IDLE;
                r_song    <= '0;
                r_pos     <= '0;
                r_ticks   <= '0;
                r_compare <= '0;
            end
            if (i_cmd.enter_gap) begin
                r_compare <= '0;
                r_phase   <= bmseq_pkg::PH_GAP;
                r_ticks   <= bmseq_pkg::TICKS_W'(gap_ticks);
            end
            if (i_cmd.advance) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.select) begin
                r_song <= sel_song;
                r_pos  <= '0;
            end
            if (i_cmd.rest_start) begin
                r_compare <= '0;
                r_phase   <= bmseq_pkg::PH_REST;
                r_ticks   <= bmseq_pkg::TICKS_W'(r_beat_ms);
            end
            if (i_cmd.note_sound) begin
                r_period  <= arr[15:0];
                r_compare <= arr[17:2];
                r_phase   <= bmseq_pkg::PH_SOUND;
                r_ticks   <= bmseq_pkg::TICKS_W'(r_beats) * bmseq_pkg::TICKS_W'(r_beat_ms);
            end
            if (i_cmd.count && (r_phase != bmseq_pkg::PH_IDLE)) begin
                r_ticks <= r_ticks - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.timer_period  <= r_period;
            r_out_data.timer_compare <= r_compare;
            r_out_data.playing       <= (r_phase != bmseq_pkg::PH_IDLE);
            r_out_data.current_song  <= r_song;
            r_out_data.note_position <= r_pos;
        end
    end

    always_comb begin
        o_status.phase      = r_phase;
        o_status.ticks_zero = (r_ticks == '0);
        o_status.last_pos   = (r_pos == bmseq_pkg::LAST_POS);
        o_status.op_load    = r_item.operation;
        o_status.btn_hit    = |r_item.buttons[2:0];
        o_status.tone_end   = (r_rd_data[15:0] == bmseq_pkg::TONE_END);
        o_status.tone_rest  = (r_rd_data[15:0] == bmseq_pkg::TONE_REST);
        o_status.div_done   = div_done;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[src/bmseq_ctrl.sv]
// ============================================================================
// Sequencer controller
// State machine that walks one beat through dispatch, phase settling, song
// selection, note start, tick count and result hand-off.
// ============================================================================
module bmseq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bmseq_pkg::t_status i_status,
    output logic               o_in_ready,
    output bmseq_pkg::t_cmd    o_cmd
);

    bmseq_pkg::t_state r_state;
    bmseq_pkg::t_state n_state;
    logic              r_selected;
    logic              n_selected;
    logic              pending;

    assign pending = (i_status.phase != bmseq_pkg::PH_IDLE) && i_status.ticks_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bmseq_pkg::ST_IDLE;
            r_selected <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_selected <= n_selected;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_selected = r_selected;
        case (r_state)
            bmseq_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bmseq_pkg::ST_DISPATCH;
                end
            end
            bmseq_pkg::ST_DISPATCH: begin
                n_selected = 1'b0;
                n_state    = i_status.op_load ? bmseq_pkg::ST_EMIT : bmseq_pkg::ST_SETTLE;
            end
            bmseq_pkg::ST_SETTLE: begin
                if (pending) begin
                    if (i_status.phase != bmseq_pkg::PH_SOUND && !i_status.last_pos) begin
                        n_state = bmseq_pkg::ST_READ;
                    end
                end else if (i_status.phase == bmseq_pkg::PH_IDLE && !r_selected) begin
                    n_state = bmseq_pkg::ST_SELECT;
                end else begin
                    n_state = bmseq_pkg::ST_COUNT;
                end
            end
            bmseq_pkg::ST_SELECT: begin
                n_selected = 1'b1;
                n_state    = i_status.btn_hit ? bmseq_pkg::ST_READ : bmseq_pkg::ST_COUNT;
            end
            bmseq_pkg::ST_READ: begin
                n_state = bmseq_pkg::ST_NOTE;
            end
            bmseq_pkg::ST_NOTE: begin
                if (i_status.tone_end || i_status.tone_rest) begin
                    n_state = bmseq_pkg::ST_SETTLE;
                end else begin
                    n_state = bmseq_pkg::ST_DIV;
                end
            end
            bmseq_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = bmseq_pkg::ST_FINISH;
                end
            end
            bmseq_pkg::ST_FINISH: begin
                n_state = bmseq_pkg::ST_SETTLE;
            end
            bmseq_pkg::ST_COUNT: begin
                n_state = bmseq_pkg::ST_EMIT;
            end
            bmseq_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = bmseq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bmseq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bmseq_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bmseq_pkg::ST_DISPATCH: begin
                o_cmd.write_note = i_status.op_load;
            end
            bmseq_pkg::ST_SETTLE: begin
                if (pending) begin
                    if (i_status.phase == bmseq_pkg::PH_SOUND) begin
                        o_cmd.enter_gap = 1'b1;
                    end else if (i_status.last_pos) begin
                        o_cmd.go_idle = 1'b1;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            bmseq_pkg::ST_SELECT: begin
                o_cmd.select = i_status.btn_hit;
            end
            bmseq_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
            end
            bmseq_pkg::ST_NOTE: begin
                if (i_status.tone_end) begin
                    o_cmd.go_idle = 1'b1;
                end else if (i_status.tone_rest) begin
                    o_cmd.rest_start = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            bmseq_pkg::ST_DIV: begin
            end
            bmseq_pkg::ST_FINISH: begin
                o_cmd.note_sound = 1'b1;
            end
            bmseq_pkg::ST_COUNT: begin
                o_cmd.count = 1'b1;
            end
            bmseq_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[src/buzzer_melody_sequencer_core.sv]
// ============================================================================
// Buzzer melody sequencer core
// PWM melody player. Load beats fill a per-song note store and tick beats,
// one per millisecond, advance the song and give the PWM timer settings.
//
// The input channel takes one beat at a time; the output channel returns one
// beat per input beat, in order, through an output register. The beat width
// is written through the configuration port; the user must write it only
// while the block is idle, which the block itself does not enforce. Each
// tone that starts within a tick beat uses the 20-step tone divider and the
// registered note store read; a rest or an end entry uses only the store
// read. Several notes may start within one tick when phases have zero
// length.
// After reset the block is idle with beat width 500 and both timer values
// at zero; the note store holds no defined content until it is loaded.
// When the receiver stalls, the finished result waits in the output
// register and the next input beat is still taken and worked on; it is
// handed over once the register frees.
// ============================================================================
module buzzer_melody_sequencer_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bmseq_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bmseq_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata
);

    bmseq_pkg::t_cmd    cmd;
    bmseq_pkg::t_status status;

    bmseq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    bmseq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/testbench.sv]
// ============================================================================
// Buzzer melody sequencer testbench
// Loads songs into the note store, plays them with one-millisecond tick beats
// and compares every returned timer setting and song status with a cycle-free
// software copy of the player, under random gaps and stalls on both channels.
// ============================================================================
module testbench;
    import bmseq_pkg::*;

    localparam logic        OP_TICK      = 1'b0;
    localparam logic        OP_LOAD      = 1'b1;
    localparam int unsigned TICK_RATE    = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1800;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    bit          no_idle = 1'b0;
    int unsigned ready_hold = 0;
    int unsigned errors = 0;
    int unsigned stim_count = 0;

    bit [15:0]   note_tone   [STORE_DEPTH];
    bit [7:0]    note_beats  [STORE_DEPTH];
    bit          note_loaded [STORE_DEPTH];
    int unsigned beat_ms_m = BEAT_MS_RESET;
    int unsigned song_m = 0;
    int unsigned pos_m = 0;
    t_phase      phase_m = PH_IDLE;
    int unsigned ticks_m = 0;
    logic [15:0] period_m = '0;
    logic [15:0] compare_m = '0;

    t_out_item   pwm_expect_q [$];
    t_out_item   want_out;

    buzzer_melody_sequencer_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_idle || $urandom_range(0, 2) != 0) begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 15);
        end else begin
            out_ready  <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    task automatic flag_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pwm_expect_q.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %h", $time, out_data);
            end else begin
                want_out = pwm_expect_q.pop_front();
                flag_field("timer_period", want_out.timer_period, out_data.timer_period);
                flag_field("timer_compare", want_out.timer_compare, out_data.timer_compare);
                flag_field("playing", want_out.playing, out_data.playing);
                flag_field("current_song", want_out.current_song, out_data.current_song);
                flag_field("note_position", want_out.note_position, out_data.note_position);
            end
        end
    end

    task automatic go_quiet();
        phase_m   = PH_IDLE;
        song_m    = 0;
        pos_m     = 0;
        ticks_m   = 0;
        compare_m = '0;
    endtask

    task automatic note_begin();
        int unsigned idx;
        int unsigned arr;
        idx = (song_m - 1) * NOTES_PER_SONG + pos_m;
        if (note_tone[idx] == TONE_END) begin
            go_quiet();
        end else if (note_tone[idx] == TONE_REST) begin
            compare_m = '0;
            phase_m   = PH_REST;
            ticks_m   = beat_ms_m;
        end else begin
            arr       = TICK_RATE / note_tone[idx] - 1;
            period_m  = arr[15:0];
            compare_m = 16'(arr / 4);
            phase_m   = PH_SOUND;
            ticks_m   = (note_beats[idx] * beat_ms_m) & 32'hFF_FFFF;
        end
    endtask

    task automatic phases_settle();
        while (phase_m != PH_IDLE && ticks_m == 0) begin
            if (phase_m == PH_SOUND) begin
                compare_m = '0;
                phase_m   = PH_GAP;
                ticks_m   = beat_ms_m / 5;
            end else if (pos_m == LAST_POS) begin
                go_quiet();
            end else begin
                pos_m++;
                note_begin();
            end
        end
    endtask

    task automatic melody_step(input t_in_item item);
        int unsigned idx;
        int s;
        bit picked;
        t_out_item res;
        if (item.operation == OP_LOAD) begin
            if (item.load_song < SONG_SLOTS) begin
                idx = int'(item.load_song) * NOTES_PER_SONG + int'(item.load_position);
                note_tone[idx]   = item.load_tone;
                note_beats[idx]  = item.load_beats;
                note_loaded[idx] = 1'b1;
            end
        end else begin
            phases_settle();
            if (phase_m == PH_IDLE) begin
                picked = 1'b0;
                for (s = 0; s < SONG_SLOTS; s++) begin
                    if (!picked && item.buttons[s]) begin
                        picked = 1'b1;
                        song_m = s + 1;
                        pos_m  = 0;
                        note_begin();
                    end
                end
                phases_settle();
            end
            if (phase_m != PH_IDLE) ticks_m--;
        end
        res.timer_period  = period_m;
        res.timer_compare = compare_m;
        res.playing       = (phase_m != PH_IDLE);
        res.current_song  = 2'(song_m);
        res.note_position = 8'(pos_m);
        pwm_expect_q.push_back(res);
    endtask

    function automatic t_in_item tick_beat(input logic [4:0] buttons);
        t_in_item b;
        b.operation     = OP_TICK;
        b.buttons       = buttons;
        b.load_song     = 2'($urandom_range(0, 3));
        b.load_position = 8'($urandom);
        b.load_tone     = 16'($urandom);
        b.load_beats    = 8'($urandom);
        return b;
    endfunction

    function automatic t_in_item load_beat(input logic [1:0] slot, input logic [7:0] pos,
                                           input logic [15:0] tone, input logic [7:0] beats);
        t_in_item b;
        b.operation     = OP_LOAD;
        b.buttons       = 5'($urandom);
        b.load_song     = slot;
        b.load_position = pos;
        b.load_tone     = tone;
        b.load_beats    = beats;
        return b;
    endfunction

    function automatic logic [15:0] random_tone();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return TONE_REST;
        if (roll < 25) return 16'($urandom_range(1, 20));
        if (roll < 35) return 16'($urandom_range(60000, 65535));
        if (roll < 60) return 16'($urandom_range(1, 65535));
        return 16'($urandom_range(100, 4000));
    endfunction

    // A song is only reachable through loaded entries, so a note or rest is kept
    // only at the last position or if the next entry already holds something.
    task automatic push_beat(input t_in_item item);
        t_in_item beat;
        int unsigned gap;
        int s;
        beat = item;
        if (beat.operation == OP_TICK) begin
            for (s = 0; s < SONG_SLOTS; s++)
                if (!note_loaded[s * NOTES_PER_SONG]) beat.buttons[s] = 1'b0;
        end else if (beat.load_song < SONG_SLOTS && beat.load_tone != TONE_END &&
                     beat.load_position != LAST_POS &&
                     !note_loaded[int'(beat.load_song) * NOTES_PER_SONG +
                                  int'(beat.load_position) + 1]) begin
            beat.load_tone = TONE_END;
        end
        gap = pick_gap();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        melody_step(beat);
        if (beat.operation == OP_TICK || beat.load_song < SONG_SLOTS) stim_count++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pwm_expect_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic play_out();
        while (phase_m != PH_IDLE) push_beat(tick_beat(5'b0));
    endtask

    task automatic set_beat_width(input logic [15:0] width);
        play_out();
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= width;
        @(posedge clk);
        cfg_we    <= 1'b0;
        beat_ms_m = width;
    endtask

    task automatic write_song(input logic [1:0] slot, input int unsigned len);
        int k;
        logic [7:0] beats;
        if (len < NOTES_PER_SONG)
            push_beat(load_beat(slot, 8'(len), TONE_END, 8'($urandom)));
        for (k = len - 1; k >= 0; k--) begin
            if (len == NOTES_PER_SONG) beats = ($urandom_range(0, 9) == 0) ? 8'd1 : 8'd0;
            else beats = 8'($urandom_range(0, 3));
            push_beat(load_beat(slot, 8'(k), random_tone(), beats));
        end
    endtask

    function automatic t_in_item stray_load();
        return load_beat(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    task automatic test_idle_after_reset();
        push_beat(tick_beat(5'b0));
        push_beat(tick_beat(5'b11000));
        push_beat(tick_beat(5'b11111));
    endtask

    task automatic test_load_bounds();
        push_beat(load_beat(2'd3, 8'd0, 16'd440, 8'd1));
        push_beat(load_beat(2'd1, 8'd0, TONE_END, 8'd255));
        push_beat(tick_beat(5'b11010));
        push_beat(tick_beat(5'b11000));
    endtask

    task automatic test_beat_width_extremes();
        set_beat_width(16'd65535);
        push_beat(tick_beat(5'b00010));
        push_beat(tick_beat(5'b0));
        set_beat_width(16'd1);
        push_beat(tick_beat(5'b11010));
    endtask

    task automatic test_basic_melody();
        set_beat_width(16'd2);
        push_beat(load_beat(2'd0, 8'd5, TONE_END, 8'd0));
        push_beat(load_beat(2'd0, 8'd4, 16'd65535, 8'd2));
        push_beat(load_beat(2'd0, 8'd3, 16'd1, 8'd0));
        push_beat(load_beat(2'd0, 8'd2, 16'd15, 8'd1));
        push_beat(load_beat(2'd0, 8'd1, TONE_REST, 8'd3));
        push_beat(load_beat(2'd0, 8'd0, 16'd440, 8'd1));
        push_beat(tick_beat(5'b00111));
        play_out();
        push_beat(tick_beat(5'b00110));
        push_beat(load_beat(2'd2, 8'd1, TONE_END, 8'd0));
        push_beat(load_beat(2'd2, 8'd0, 16'd2000, 8'd1));
        push_beat(tick_beat(5'b11100));
        play_out();
    endtask

    task automatic test_zero_length_notes();
        set_beat_width(16'd1);
        push_beat(load_beat(2'd1, 8'd3, TONE_END, 8'd7));
        push_beat(load_beat(2'd1, 8'd2, 16'd3000, 8'd0));
        push_beat(load_beat(2'd1, 8'd1, 16'd7, 8'd0));
        push_beat(load_beat(2'd1, 8'd0, 16'd500, 8'd0));
        push_beat(tick_beat(5'b00010));
        play_out();
    endtask

    task automatic test_random_traffic();
        int unsigned widths [9] = '{1, 2, 3, 4, 5, 6, 8, 10, 13};
        stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            set_beat_width(16'(widths[$urandom_range(0, 8)]));
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 14) == 0)
                    write_song(2'($urandom_range(0, 2)), NOTES_PER_SONG);
                else
                    write_song(2'($urandom_range(0, 2)), $urandom_range(1, 8));
            end
            repeat ($urandom_range(0, 3)) push_beat(stray_load());
            repeat ($urandom_range(20, 80)) begin
                if ($urandom_range(0, 9) == 0) push_beat(stray_load());
                if ($urandom_range(0, 1) == 0) push_beat(tick_beat(5'($urandom)));
                else push_beat(tick_beat(5'b0));
            end
            play_out();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_after_reset();
        test_load_bounds();
        test_beat_width_extremes();
        test_basic_melody();
        test_zero_length_notes();
        test_random_traffic();
        play_out();
        wait_quiet();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
